// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the profiler RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define ASSERT_CLKD(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, also during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/nelp_pkg.sv =====
// ----------------------------------------------------------------------------
// nelp_pkg
// Types and constants shared by the nested event latency profiler modules.
// ----------------------------------------------------------------------------
`default_nettype none

package nelp_pkg;

  localparam int ID_W       = 10;
  localparam int PID_W      = 22;
  localparam int TS_W       = 64;
  localparam int RET_W      = 64;
  localparam int CNT_W      = 32;
  localparam int IN_DATA_W  = 160;
  localparam int OUT_DATA_W = 304;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  // register index, taken from paddr[2]
  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_TARGET = 1'b1;

  localparam logic REQ_ENTER = 1'b0;
  localparam logic REQ_EXIT  = 1'b1;

  typedef struct packed {
    logic             enable;
    logic [PID_W-1:0] target;
  } cfg_t;

  typedef struct packed {
    logic clr_we;
    logic capture;
    logic push;
    logic pop;
    logic calc;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic evt_ok;
    logic is_exit;
    logic full;
    logic empty;
    logic id_match;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== hdl/nelp_ram.sv =====
// ----------------------------------------------------------------------------
// nelp_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module nelp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/nelp_regs.sv =====
// ----------------------------------------------------------------------------
// nelp_regs
// APB register file: enable and target process id.
// ----------------------------------------------------------------------------
`default_nettype none

module nelp_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [nelp_pkg::APB_AW-1:0]   paddr,
  input  wire logic [nelp_pkg::APB_DW-1:0]   pwdata,
  output logic      [nelp_pkg::APB_DW-1:0]   prdata,
  output logic                               pready,
  output nelp_pkg::cfg_t                     cfg
);
  import nelp_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable <= 1'b0;
      cfg.target <= '0;
    end else if (wr_en) begin
      case (paddr[2])
        REG_ENABLE: cfg.enable <= pwdata[0];
        REG_TARGET: cfg.target <= pwdata[PID_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ENABLE: prdata = {{(APB_DW-1){1'b0}}, cfg.enable};
      REG_TARGET: prdata = {{(APB_DW-PID_W){1'b0}}, cfg.target};
      default:    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/nelp_ctrl.sv =====
// ----------------------------------------------------------------------------
// nelp_ctrl
// Controller: accumulator clearing, event accept and per-event sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module nelp_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  output logic                s_tready,
  input  nelp_pkg::sts_t      sts,
  output nelp_pkg::cmd_t      cmd
);
  import nelp_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_CALC   = 3'd3;
  localparam logic [2:0] ST_COMMIT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_next = ST_IDLE;
        if (sts.evt_ok) begin
          if (!sts.is_exit) begin
            cmd.push = !sts.full;
          end else if (!sts.empty) begin
            cmd.pop    = 1'b1;
            state_next = ST_CALC;
          end
        end
      end
      ST_CALC: begin
        cmd.calc   = 1'b1;
        state_next = sts.id_match ? ST_COMMIT : ST_IDLE;
      end
      ST_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/nelp_dp.sv =====
// ----------------------------------------------------------------------------
// nelp_dp
// Datapath: event register, call stack, per-id accumulators, result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module nelp_dp #(
  parameter int NUM_IDS     = 512,
  parameter int STACK_DEPTH = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  nelp_pkg::cfg_t                         cfg,
  input  nelp_pkg::cmd_t                         cmd,
  output nelp_pkg::sts_t                         sts,
  input  wire logic [nelp_pkg::IN_DATA_W-1:0]    s_tdata,
  input  wire logic                              s_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic      [nelp_pkg::OUT_DATA_W-1:0]   m_tdata
);
  import nelp_pkg::*;

  localparam int SAW   = $clog2(STACK_DEPTH);
  localparam int DW    = $clog2(STACK_DEPTH + 1);
  localparam int IW    = $clog2(NUM_IDS);
  localparam int SW    = ID_W + TS_W;
  localparam int ACC_W = TS_W + CNT_W;
  localparam int PAD_W = OUT_DATA_W - (ID_W + RET_W + 3 * TS_W + CNT_W);

  logic             ev_exit;
  logic [ID_W-1:0]  ev_id;
  logic [PID_W-1:0] ev_pid;
  logic [TS_W-1:0]  ev_time;
  logic [RET_W-1:0] ev_ret;

  logic [DW-1:0]    depth;
  logic [DW-1:0]    depth_dec;
  logic [SW-1:0]    stk_rdata;
  logic [ID_W-1:0]  top_id;
  logic [TS_W-1:0]  top_time;

  logic [IW-1:0]    clr_addr;
  logic [IW-1:0]    acc_waddr;
  logic [ACC_W-1:0] acc_wdata;
  logic [ACC_W-1:0] acc_rdata;
  logic             acc_we;

  logic [TS_W-1:0]  delta;
  logic [CNT_W-1:0] count_new;
  logic [TS_W-1:0]  total_new;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ev_exit <= s_tuser;
      ev_id   <= s_tdata[9:0];
      ev_pid  <= s_tdata[31:10];
      ev_time <= s_tdata[95:32];
      ev_ret  <= s_tdata[159:96];
    end
  end

  // call stack
  assign depth_dec = depth - DW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (cmd.push) begin
      depth <= depth + DW'(1);
    end else if (cmd.pop) begin
      depth <= depth_dec;
    end
  end

  nelp_ram #(
    .WIDTH (SW),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (depth[SAW-1:0]),
    .wdata ({ev_id, ev_time}),
    .re    (cmd.pop),
    .raddr (depth_dec[SAW-1:0]),
    .rdata (stk_rdata)
  );

  assign top_id   = stk_rdata[SW-1:TS_W];
  assign top_time = stk_rdata[TS_W-1:0];

  // per-id accumulators {time, count}
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_we) begin
      clr_addr <= clr_addr + IW'(1);
    end
  end

  assign total_new = acc_rdata[ACC_W-1:CNT_W] + delta;
  assign acc_we    = cmd.clr_we || cmd.commit;
  assign acc_waddr = cmd.clr_we ? clr_addr : ev_id[IW-1:0];
  assign acc_wdata = cmd.clr_we ? '0 : {total_new, count_new};

  nelp_ram #(
    .WIDTH (ACC_W),
    .DEPTH (NUM_IDS)
  ) u_acc (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .re    (cmd.pop),
    .raddr (ev_id[IW-1:0]),
    .rdata (acc_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      delta     <= ev_time - top_time;
      count_new <= acc_rdata[CNT_W-1:0] + CNT_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tdata <= {{PAD_W{1'b0}}, total_new, count_new, ev_time, delta, ev_ret, ev_id};
    end
  end

  assign sts.clr_last = (clr_addr == IW'(NUM_IDS - 1));
  assign sts.evt_ok   = cfg.enable && ({1'b0, ev_id} < (ID_W + 1)'(NUM_IDS))
                        && (ev_pid == cfg.target);
  assign sts.is_exit  = (ev_exit == REQ_EXIT);
  assign sts.full     = (depth == DW'(STACK_DEPTH));
  assign sts.empty    = (depth == '0);
  assign sts.id_match = (top_id == ev_id);
  assign sts.out_free = !m_tvalid || m_tready;

  `ASSERT_CLKD(a_push_not_full, clk, rst, cmd.push |-> !sts.full,
               "push onto full stack")
  `ASSERT_CLKD(a_pop_not_empty, clk, rst, cmd.pop |-> !sts.empty,
               "pop from empty stack")
  `ASSERT_CLKD(a_commit_free, clk, rst, cmd.commit |-> sts.out_free,
               "result overwritten while pending")
  `ASSERT_CLKD(a_depth_range, clk, rst, depth <= DW'(STACK_DEPTH),
               "stack depth out of range")

endmodule

`default_nettype wire

// ===== hdl/nested_event_latency_profiler_top.sv =====
// ----------------------------------------------------------------------------
// nested_event_latency_profiler_top
// Matches enter/exit events of one process and reports per-call latency.
// ----------------------------------------------------------------------------
// Input stream s_*: one event per request, s_tuser = 0 enter, 1 exit.
// Output stream m_*: one result per exit whose id matches the stack top.
// APB port: 0x0 enable, 0x4 target process id; write only while idle.
// After reset the per-id accumulators are swept to zero, one id per
// cycle, with s_tready low; APB writes are taken meanwhile.
// An accepted event is captured, then decided; filtered events, enters and
// empty-stack exits end there, other exits go on to a calc step and, on an
// id match, to a commit step, bound by the registered reads of the stack and
// accumulator memories. A matched exit's result is written in its commit step.
// A result sits in the output register until m_tready; a matched exit
// waits in its last step while that register is still full, and s_tready
// stays low until it is written, so no new request is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module nested_event_latency_profiler_top #(
  parameter int NUM_IDS     = 512,
  parameter int STACK_DEPTH = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // APB configuration
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [nelp_pkg::APB_AW-1:0]       paddr,
  input  wire logic [nelp_pkg::APB_DW-1:0]       pwdata,
  output logic      [nelp_pkg::APB_DW-1:0]       prdata,
  output logic                                   pready,
  // events
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // event_id[9:0], process_id[31:10], time_now[95:32], return_value[159:96]
  input  wire logic [nelp_pkg::IN_DATA_W-1:0]    s_tdata,
  // req_type
  input  wire logic                              s_tuser,
  // results
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // done_id[9:0], done_return[73:10], duration[137:74], end_time[201:138],
  // id_count[233:202], id_total_time[297:234], zero[303:298]
  output logic      [nelp_pkg::OUT_DATA_W-1:0]   m_tdata
);
  import nelp_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  nelp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  nelp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nelp_dp #(
    .NUM_IDS     (NUM_IDS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire
